// ----- rtl/dhs_pkg.sv -----
// Package for the depth heap sorter: item layout, widths and the
// command/status bundles between controller and datapath. No dependencies.
package dhs_pkg;

  localparam int unsigned DEPTH_W = 32;
  localparam int unsigned TAG_W   = 16;
  localparam int unsigned ITEM_W  = DEPTH_W + TAG_W;

  // One stored entry: signed key with its tag.
  typedef struct packed {
    logic signed [DEPTH_W-1:0] depth;
    logic        [TAG_W-1:0]   tag;
  } item_t;

  // Commands from the controller, one bit per datapath action.
  typedef struct packed {
    logic in_rdy;    // accept input beats and store them
    logic bld_init;  // set heap size and first parent of the build pass
    logic bld_rd;    // read the current build parent
    logic bld_ld;    // latch the build parent as the item being sifted
    logic bp_dec;    // step to the previous build parent
    logic sift_rd;   // read both children, or park the sifted item
    logic sift_cmp;  // pick the smaller child and move it or park the item
    logic srt_rd;    // read root and end of the unsorted part
    logic srt_ld;    // move root to the end, start sifting the old end item
    logic emit_rd;   // read the next sorted entry
    logic emit_ld;   // load the output register
    logic emit_next; // advance the output position
    logic out_vld;   // output register holds a beat
    logic clear;     // end of list: reset count, flag and position
  } cmd_t;

  // Status returned by the datapath.
  typedef struct packed {
    logic in_fire;
    logic in_last;
    logic out_fire;
    logic cnt_lt2;
    logic bp_zero;
    logic c_ge_size;
    logic stop;
    logic size_gt1;
    logic out_last;
  } sts_t;

endpackage

// ----- rtl/dhs_in_if.sv -----
// Input channel of the depth heap sorter: valid/ready plus one item.
// Depends on dhs_pkg for field widths.
interface dhs_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [dhs_pkg::DEPTH_W-1:0]   depth;
  logic        [dhs_pkg::TAG_W-1:0]     tag;
  logic                                 last_item;

  modport source (output valid, depth, tag, last_item, input ready);
  modport sink   (input valid, depth, tag, last_item, output ready);
endinterface

// ----- rtl/dhs_out_if.sv -----
// Output channel of the depth heap sorter: valid/ready plus one result.
// Depends on dhs_pkg for field widths.
interface dhs_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [dhs_pkg::DEPTH_W-1:0]   sorted_depth;
  logic        [dhs_pkg::TAG_W-1:0]     sorted_tag;
  logic                                 overflow;
  logic                                 last_result;

  modport source (output valid, sorted_depth, sorted_tag, overflow, last_result, input ready);
  modport sink   (input valid, sorted_depth, sorted_tag, overflow, last_result, output ready);
endinterface

// ----- rtl/dhs_ram.sv -----
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
module dhs_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_a_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_b_i,
  output logic [WIDTH-1:0]         rdata_a_o,
  output logic [WIDTH-1:0]         rdata_b_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and both registered read ports.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

// ----- rtl/dhs_ctrl.sv -----
// Controller of the depth heap sorter: sequences load, heap build,
// sort and output phases. Depends on dhs_pkg.
module dhs_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  dhs_pkg::sts_t  sts_i,
  output dhs_pkg::cmd_t  cmd_o
);

  localparam logic [3:0] ST_LOAD      = 4'd0;
  localparam logic [3:0] ST_BLD_INIT  = 4'd1;
  localparam logic [3:0] ST_BLD_RD    = 4'd2;
  localparam logic [3:0] ST_BLD_LD    = 4'd3;
  localparam logic [3:0] ST_SIFT_RD   = 4'd4;
  localparam logic [3:0] ST_SIFT_CMP  = 4'd5;
  localparam logic [3:0] ST_SRT_RD    = 4'd6;
  localparam logic [3:0] ST_SRT_LD    = 4'd7;
  localparam logic [3:0] ST_EMIT_RD   = 4'd8;
  localparam logic [3:0] ST_EMIT_LD   = 4'd9;
  localparam logic [3:0] ST_EMIT_WAIT = 4'd10;

  logic [3:0] state_q, state_d;
  logic       sort_q, sort_d;     // 0 while building the heap, 1 while sorting
  logic [3:0] after_sift;
  logic       after_sort;
  logic       after_dec;

  // Where to go when a sift-down has finished.
  always_comb begin
    after_sort = sort_q;
    after_dec  = 1'b0;
    if (!sort_q) begin
      if (sts_i.bp_zero) begin
        after_sort = 1'b1;
        after_sift = sts_i.size_gt1 ? ST_SRT_RD : ST_EMIT_RD;
      end else begin
        after_dec  = 1'b1;
        after_sift = ST_BLD_RD;
      end
    end else begin
      after_sift = sts_i.size_gt1 ? ST_SRT_RD : ST_EMIT_RD;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    sort_d  = sort_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_LOAD: begin
        cmd_o.in_rdy = 1'b1;
        if (sts_i.in_fire && sts_i.in_last) begin
          state_d = ST_BLD_INIT;
        end
      end
      ST_BLD_INIT: begin
        cmd_o.bld_init = 1'b1;
        sort_d         = 1'b0;
        state_d        = sts_i.cnt_lt2 ? ST_EMIT_RD : ST_BLD_RD;
      end
      ST_BLD_RD: begin
        cmd_o.bld_rd = 1'b1;
        state_d      = ST_BLD_LD;
      end
      ST_BLD_LD: begin
        cmd_o.bld_ld = 1'b1;
        state_d      = ST_SIFT_RD;
      end
      ST_SIFT_RD: begin
        cmd_o.sift_rd = 1'b1;
        if (sts_i.c_ge_size) begin
          cmd_o.bp_dec = after_dec;
          sort_d       = after_sort;
          state_d      = after_sift;
        end else begin
          state_d = ST_SIFT_CMP;
        end
      end
      ST_SIFT_CMP: begin
        cmd_o.sift_cmp = 1'b1;
        if (sts_i.stop) begin
          cmd_o.bp_dec = after_dec;
          sort_d       = after_sort;
          state_d      = after_sift;
        end else begin
          state_d = ST_SIFT_RD;
        end
      end
      ST_SRT_RD: begin
        cmd_o.srt_rd = 1'b1;
        state_d      = ST_SRT_LD;
      end
      ST_SRT_LD: begin
        cmd_o.srt_ld = 1'b1;
        state_d      = ST_SIFT_RD;
      end
      ST_EMIT_RD: begin
        cmd_o.emit_rd = 1'b1;
        state_d       = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        cmd_o.emit_ld = 1'b1;
        state_d       = ST_EMIT_WAIT;
      end
      ST_EMIT_WAIT: begin
        cmd_o.out_vld = 1'b1;
        if (sts_i.out_fire) begin
          if (sts_i.out_last) begin
            cmd_o.clear = 1'b1;
            state_d     = ST_LOAD;
          end else begin
            cmd_o.emit_next = 1'b1;
            state_d         = ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      sort_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      sort_q  <= sort_d;
    end
  end

endmodule

// ----- rtl/dhs_dpath.sv -----
// Datapath of the depth heap sorter: item store, heap indexes, the item
// being sifted and the output register. Depends on dhs_pkg, dhs_ram and
// the channel interfaces.
module dhs_dpath #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  dhs_in_if.sink         in_i,
  dhs_out_if.source      out_o,
  input  dhs_pkg::cmd_t  cmd_i,
  output dhs_pkg::sts_t  sts_o
);

  localparam int unsigned AW = $clog2(MAX_ITEMS);      // store address
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);  // item count
  localparam int unsigned XW = AW + 1;                 // child index

  // Control state.
  logic [CW-1:0] count_q, count_d;
  logic          drop_q, drop_d;
  logic [AW-1:0] k_q, k_d;

  // Heap working registers.
  logic [CW-1:0]  size_q;
  logic [AW-1:0]  bp_q;
  logic [AW-1:0]  p_q;
  logic [XW-1:0]  c_q;
  dhs_pkg::item_t pitem_q;

  // Output register.
  dhs_pkg::item_t out_item_q;
  logic           out_ovf_q;
  logic           out_last_q;

  // Store ports.
  logic                       we;
  logic [AW-1:0]              waddr;
  dhs_pkg::item_t             wdata;
  logic [AW-1:0]              raddr_a, raddr_b;
  logic [dhs_pkg::ITEM_W-1:0] rdata_a_raw, rdata_b_raw;
  dhs_pkg::item_t             rd_a, rd_b;

  logic           in_fire, out_fire, not_full;
  logic [XW-1:0]  size_x, c1, s_x;
  logic           sel_right, stop;
  dhs_pkg::item_t sitem;

  assign in_fire  = in_i.valid & in_i.ready;
  assign out_fire = out_o.valid & out_o.ready;
  assign not_full = count_q < CW'(MAX_ITEMS);
  assign rd_a     = rdata_a_raw;
  assign rd_b     = rdata_b_raw;

  // Child selection: the right child wins ties, the parent moves only on
  // a strictly smaller child.
  assign size_x    = XW'(size_q);
  assign c1        = c_q + 1'b1;
  assign sel_right = (c1 < size_x) && !(rd_a.depth < rd_b.depth);
  assign sitem     = sel_right ? rd_b : rd_a;
  assign s_x       = sel_right ? c1 : c_q;
  assign stop      = sitem.depth >= pitem_q.depth;

  // Store write and read addresses.
  always_comb begin
    we      = 1'b0;
    waddr   = p_q;
    wdata   = pitem_q;
    raddr_a = '0;
    raddr_b = '0;
    if (cmd_i.in_rdy) begin
      we    = in_fire & not_full;
      waddr = count_q[AW-1:0];
      wdata = '{depth: in_i.depth, tag: in_i.tag};
    end
    if (cmd_i.bld_rd) begin
      raddr_a = bp_q;
    end
    if (cmd_i.sift_rd) begin
      we      = (c_q >= size_x);
      raddr_a = c_q[AW-1:0];
      raddr_b = c1[AW-1:0];
    end
    if (cmd_i.sift_cmp) begin
      we    = 1'b1;
      wdata = stop ? pitem_q : sitem;
    end
    if (cmd_i.srt_rd) begin
      raddr_b = AW'(size_q - 1'b1);
    end
    if (cmd_i.srt_ld) begin
      we    = 1'b1;
      waddr = AW'(size_q - 1'b1);
      wdata = rd_a;
    end
    if (cmd_i.emit_rd) begin
      raddr_a = k_q;
    end
  end

  dhs_ram #(
    .WIDTH (dhs_pkg::ITEM_W),
    .DEPTH (MAX_ITEMS)
  ) u_store (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a_raw),
    .rdata_b_o (rdata_b_raw)
  );

  // Count, overflow flag and output position.
  always_comb begin
    count_d = count_q;
    drop_d  = drop_q;
    k_d     = k_q;
    if (cmd_i.in_rdy && in_fire) begin
      if (not_full) begin
        count_d = count_q + 1'b1;
      end else begin
        drop_d = 1'b1;
      end
    end
    if (cmd_i.emit_next) begin
      k_d = k_q + 1'b1;
    end
    if (cmd_i.clear) begin
      count_d = '0;
      drop_d  = 1'b0;
      k_d     = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      drop_q  <= 1'b0;
      k_q     <= '0;
    end else begin
      count_q <= count_d;
      drop_q  <= drop_d;
      k_q     <= k_d;
    end
  end

  // Heap indexes, sifted item and output register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.bld_init) begin
      size_q <= count_q;
      bp_q   <= AW'((count_q >> 1) - 1'b1);
    end
    if (cmd_i.bp_dec) begin
      bp_q <= bp_q - 1'b1;
    end
    if (cmd_i.bld_ld) begin
      pitem_q <= rd_a;
      p_q     <= bp_q;
      c_q     <= {bp_q, 1'b1};
    end
    if (cmd_i.sift_cmp && !stop) begin
      p_q <= s_x[AW-1:0];
      c_q <= {s_x[AW-1:0], 1'b1};
    end
    if (cmd_i.srt_ld) begin
      pitem_q <= rd_b;
      size_q  <= size_q - 1'b1;
      p_q     <= '0;
      c_q     <= XW'(1);
    end
    if (cmd_i.emit_ld) begin
      out_item_q <= rd_a;
      out_ovf_q  <= drop_q;
      out_last_q <= (k_q == AW'(count_q - 1'b1));
    end
  end

  // Channel signals.
  assign in_i.ready         = cmd_i.in_rdy;
  assign out_o.valid        = cmd_i.out_vld;
  assign out_o.sorted_depth = out_item_q.depth;
  assign out_o.sorted_tag   = out_item_q.tag;
  assign out_o.overflow     = out_ovf_q;
  assign out_o.last_result  = out_last_q;

  // Status to the controller.
  assign sts_o.in_fire   = in_fire;
  assign sts_o.in_last   = in_i.last_item;
  assign sts_o.out_fire  = out_fire;
  assign sts_o.cnt_lt2   = count_q < CW'(2);
  assign sts_o.bp_zero   = (bp_q == '0);
  assign sts_o.c_ge_size = (c_q >= size_x);
  assign sts_o.stop      = stop;
  assign sts_o.size_gt1  = size_q > CW'(1);
  assign sts_o.out_last  = out_last_q;

endmodule

// ----- rtl/depth_heap_sort.sv -----
// Depth heap sorter top level: a controller and a datapath around one
// item store. Depends on dhs_pkg, dhs_in_if, dhs_out_if, dhs_ctrl, dhs_dpath.
//
// Usage: items (signed depth, tag, last mark) arrive on in_i, one beat per
// cycle while the block is loading. The beat marked last closes the list;
// the block then stops taking input, heapsorts the stored items with a
// min-heap and sends them on out_o in non-increasing depth order, one beat
// per stored item, with the final beat marked and the overflow bit set when
// beats beyond MAX_ITEMS were dropped. After the final beat is taken the
// block is back in the load phase with an empty list.
// The sort is set by the single write port of the store. Each heap level
// of a sift-down takes a read state and a compare state (ST_SIFT_RD and
// ST_SIFT_CMP). The build pass sifts each parent from the last one down
// to the root; the sort pass then moves the root to the end of the
// unsorted part and sifts the old end item. Each output beat passes read,
// load and wait states; the next entry is read only once the beat is taken.
// Reset clears the count, the overflow flag and the control state; the
// store needs no clearing. A stalled receiver holds the current beat in the
// output register and the block waits.
module depth_heap_sort #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  dhs_in_if.sink     in_i,
  dhs_out_if.source  out_o
);

  dhs_pkg::cmd_t cmd;
  dhs_pkg::sts_t sts;

  dhs_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  dhs_dpath #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_dpath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .out_o  (out_o),
    .cmd_i  (cmd),
    .sts_o  (sts)
  );

endmodule
